@@ rtl/xbs_pkg.sv @@
// Shared types and constants for the XMODEM block sender.
// No dependencies; xbs_front, xbs_core and the top level refer to this package.
package xbs_pkg;

    // Queue depth on both sides of the execution core.
    localparam int FIFO_DEPTH = 2;

    // Classified input word.
    typedef enum logic [1:0] {
        OP_PAYLOAD = 2'd0,
        OP_EOF     = 2'd1,
        OP_RX      = 2'd2,
        OP_SLOT    = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       accepted;
        logic [2:0] phase;
        logic [7:0] block_number;
    } t_result;

endpackage

@@ rtl/xbs_fifo.sv @@
// Small synchronous queue with full/empty flags.
// Depends on nothing; used by xbs_front and by the top level for results.
module xbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

@@ rtl/xbs_front.sv @@
// Front end: takes input words, classifies the action and queues them for the core.
// Depends on xbs_pkg and xbs_fifo.
module xbs_front #(
    parameter int FIFO_DEPTH = xbs_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [1:0]    i_action,
    input  logic [7:0]    i_data_byte,
    output logic          o_full,
    output logic          o_valid,
    output xbs_pkg::t_item o_item,
    input  logic          i_take
);
    xbs_pkg::t_item item_in;
    logic           q_empty;

    always_comb begin
        case (i_action)
            xbs_pkg::OP_PAYLOAD: item_in.op = xbs_pkg::OP_PAYLOAD;
            xbs_pkg::OP_EOF:     item_in.op = xbs_pkg::OP_EOF;
            xbs_pkg::OP_RX:      item_in.op = xbs_pkg::OP_RX;
            default:             item_in.op = xbs_pkg::OP_SLOT;
        endcase
        item_in.data = i_data_byte;
    end

    xbs_fifo #(
        .WIDTH ($bits(xbs_pkg::t_item)),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (item_in),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_rdata (o_item),
        .o_empty (q_empty)
    );

    assign o_valid = ~q_empty;

endmodule

@@ rtl/xbs_core.sv @@
// Back end: protocol state machine, block store, checksum/CRC and framing.
// Depends on xbs_pkg.
module xbs_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_valid,
    input  xbs_pkg::t_item   i_item,
    output logic             o_take,
    input  logic             i_res_full,
    output logic             o_res_push,
    output xbs_pkg::t_result o_result
);
    localparam int          BLOCK_LEN = 128;
    localparam int          HDR_LEN   = 3;
    localparam int          IDX_W     = $clog2(BLOCK_LEN);
    localparam logic [7:0]  DATA_END  = 8'(HDR_LEN + BLOCK_LEN);
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_NAK  = 8'h15;
    localparam logic [7:0] CH_CAN  = 8'h18;
    localparam logic [7:0] CH_CSYN = 8'h43;

    typedef enum logic [2:0] {
        PH_SYNC   = 3'd0,
        PH_LOAD   = 3'd1,
        PH_SEND   = 3'd2,
        PH_WAIT   = 3'd3,
        PH_EOT    = 3'd4,
        PH_DONE   = 3'd5,
        PH_CANCEL = 3'd6,
        PH_ERROR  = 3'd7
    } t_phase;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

    t_phase      r_phase, n_phase;
    logic [7:0]  r_fill, n_fill;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_blk, n_blk;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_crc, n_crc;
    logic        r_end, n_end;
    logic        r_crc_mode;

    logic [7:0]  r_store [BLOCK_LEN];
    logic [7:0]  r_rd_data;

    logic        acc, txv, store_we;
    logic [7:0]  txb, data_idx, rd_off, last_pos, data_byte;

    assign o_take     = i_valid & ~i_res_full;
    assign o_res_push = o_take;

    // store is read ahead through a register, at the byte the next send position will need
    assign rd_off   = n_pos - 8'(HDR_LEN);
    assign data_idx = r_pos - 8'(HDR_LEN);
    assign last_pos = r_crc_mode ? DATA_END + 8'd1 : DATA_END;
    assign data_byte = (data_idx < r_fill) ? r_rd_data : 8'h00;

    always_comb begin
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_pos    = r_pos;
        n_blk    = r_blk;
        n_sum    = r_sum;
        n_crc    = r_crc;
        n_end    = r_end;
        acc      = 1'b0;
        txv      = 1'b0;
        txb      = 8'h00;
        store_we = 1'b0;
        if (o_take) begin
            case (i_item.op)
                xbs_pkg::OP_PAYLOAD: begin
                    if (r_phase == PH_LOAD) begin
                        acc      = 1'b1;
                        store_we = (r_fill < 8'(BLOCK_LEN));
                        n_fill   = r_fill + 8'd1;
                        if (n_fill >= 8'(BLOCK_LEN)) begin
                            n_phase = PH_SEND;
                            n_pos   = 8'd0;
                        end
                    end
                end
                xbs_pkg::OP_EOF: begin
                    if (r_phase == PH_LOAD) begin
                        acc = 1'b1;
                        if (r_fill == 8'd0) begin
                            n_phase = PH_EOT;
                        end else begin
                            n_end   = 1'b1;
                            n_phase = PH_SEND;
                            n_pos   = 8'd0;
                        end
                    end
                end
                xbs_pkg::OP_RX: begin
                    if (r_phase == PH_SYNC) begin
                        acc = 1'b1;
                        if (i_item.data == (r_crc_mode ? CH_CSYN : CH_NAK)) begin
                            n_phase = PH_LOAD;
                        end
                    end else if (r_phase == PH_WAIT) begin
                        acc = 1'b1;
                        if (i_item.data == CH_ACK) begin
                            if (r_end) begin
                                n_phase = PH_EOT;
                            end else begin
                                n_blk   = r_blk + 8'd1;
                                n_fill  = 8'd0;
                                n_phase = PH_LOAD;
                            end
                        end else if (i_item.data == CH_NAK) begin
                            n_phase = PH_SEND;
                            n_pos   = 8'd0;
                        end else if (i_item.data == CH_CAN) begin
                            n_phase = PH_CANCEL;
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end
                end
                xbs_pkg::OP_SLOT: begin
                    if (r_phase == PH_SEND) begin
                        acc = 1'b1;
                        txv = 1'b1;
                        if (r_pos == 8'd0) begin
                            n_sum = 8'h00;
                            n_crc = 16'h0000;
                            txb   = CH_SOH;
                        end else if (r_pos == 8'd1) begin
                            txb = r_blk;
                        end else if (r_pos == 8'd2) begin
                            txb = ~r_blk;
                        end else if (r_pos < DATA_END) begin
                            txb   = data_byte;
                            n_sum = r_sum + data_byte;
                            n_crc = crc_byte(r_crc, data_byte);
                        end else if (!r_crc_mode) begin
                            txb = r_sum;
                        end else if (r_pos == DATA_END) begin
                            txb = r_crc[15:8];
                        end else begin
                            txb = r_crc[7:0];
                        end
                        if (r_pos >= last_pos) begin
                            n_phase = PH_WAIT;
                            n_pos   = 8'd0;
                        end else begin
                            n_pos = r_pos + 8'd1;
                        end
                    end else if (r_phase == PH_EOT) begin
                        acc     = 1'b1;
                        txv     = 1'b1;
                        txb     = CH_EOT;
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    acc = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_result.tx_valid     = txv;
        o_result.tx_byte      = txb;
        o_result.accepted     = acc;
        o_result.phase        = 3'(n_phase);
        o_result.block_number = n_blk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC;
            r_fill     <= 8'd0;
            r_pos      <= 8'd0;
            r_blk      <= 8'd1;
            r_sum      <= 8'h00;
            r_crc      <= 16'h0000;
            r_end      <= 1'b0;
            r_crc_mode <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_pos   <= n_pos;
            r_blk   <= n_blk;
            r_sum   <= n_sum;
            r_crc   <= n_crc;
            r_end   <= n_end;
            if (i_cfg_we) begin
                r_crc_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_fill[IDX_W-1:0]] <= i_item.data;
        end
        r_rd_data <= r_store[rd_off[IDX_W-1:0]];
    end

endmodule

@@ rtl/xmodem_block_sender_top.sv @@
// XMODEM sender top level: front queue, execution core, result queue.
// Depends on xbs_pkg, xbs_fifo, xbs_front and xbs_core.
//
//   channel   direction  handshake            payload
//   item      in         push / full          i_action, i_data_byte
//   result    out        empty / pop          o_tx_valid, o_tx_byte, o_accepted,
//                                             o_phase, o_block_number
//   config    in         i_cfg_we (no wait)   i_cfg_wdata (crc_mode)
//
// One word per cycle sustained while the result queue has room; a result shows on
// the result ports, ready to pop, once its word passes the input and result queues.
// Core steps once per cycle unless results are full; store data is read ahead of use.
// Reset is synchronous: both queues empty, sync phase, block 1, CRC mode.
// A stalled result side fills the result queue, then the input queue, then full rises.
module xmodem_block_sender_top #(
    parameter int FIFO_DEPTH = xbs_pkg::FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_accepted,
    output logic [2:0] o_phase,
    output logic [7:0] o_block_number,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);
    xbs_pkg::t_item   item;
    xbs_pkg::t_result core_res, out_res;
    logic             item_valid, take, res_push, res_full;

    xbs_front #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .o_full      (full),
        .o_valid     (item_valid),
        .o_item      (item),
        .i_take      (take)
    );

    xbs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (item_valid),
        .i_item      (item),
        .o_take      (take),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_result    (core_res)
    );

    xbs_fifo #(
        .WIDTH ($bits(xbs_pkg::t_result)),
        .DEPTH (FIFO_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (core_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (out_res),
        .o_empty (empty)
    );

    assign o_tx_valid     = out_res.tx_valid;
    assign o_tx_byte      = out_res.tx_byte;
    assign o_accepted     = out_res.accepted;
    assign o_phase        = out_res.phase;
    assign o_block_number = out_res.block_number;

endmodule

@@ dv/tb_xmodem_block_sender_top.sv @@
// Self-checking testbench for the XMODEM block sender (xmodem_block_sender_top).
// Depends on xbs_pkg and the RTL under rtl/; stands alone otherwise.
// A word-level model tracks the sender and checks every result word in order.
`timescale 1ns / 1ps

module tb_xmodem_block_sender_top;

    typedef enum logic [2:0] {
        PH_SYNC   = 3'd0,
        PH_LOAD   = 3'd1,
        PH_SEND   = 3'd2,
        PH_WAIT   = 3'd3,
        PH_EOT    = 3'd4,
        PH_DONE   = 3'd5,
        PH_CANCEL = 3'd6,
        PH_ERROR  = 3'd7
    } t_phase;

    localparam logic [7:0] CH_SOH    = 8'h01;
    localparam logic [7:0] CH_EOT    = 8'h04;
    localparam logic [7:0] CH_ACK    = 8'h06;
    localparam logic [7:0] CH_NAK    = 8'h15;
    localparam logic [7:0] CH_CAN    = 8'h18;
    localparam logic [7:0] CH_SYNC_C = 8'h43;
    localparam int BLOCK_LEN     = 128;
    localparam int TAKEN_TARGET  = 1700;
    localparam int WATCHDOG_IDLE = 2000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] i_action = 2'd0;
    logic [7:0] i_data_byte = 8'd0;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_accepted;
    logic [2:0] o_phase;
    logic [7:0] o_block_number;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;

    xmodem_block_sender_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .empty          (empty),
        .pop            (pop),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_accepted     (o_accepted),
        .o_phase        (o_phase),
        .o_block_number (o_block_number),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // sender model state
    logic       m_crc_mode = 1'b1;
    t_phase     m_phase = PH_SYNC;
    logic [7:0] m_store [BLOCK_LEN];
    logic [7:0] m_fill = 8'd0;
    logic [7:0] m_pos = 8'd0;
    logic [7:0] m_blk = 8'd1;
    logic [7:0] m_sum = 8'd0;
    logic [15:0] m_crc = 16'd0;
    logic       m_end = 1'b0;

    xbs_pkg::t_result expected_results [$];
    int  error_count = 0;
    int  taken_count = 0;
    int  rejected_count = 0;
    int  blocks_sent = 0;
    int  resends = 0;
    int  mode_writes = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    string end_name = "none";

    function automatic xbs_pkg::t_result step_sender(input xbs_pkg::t_op op,
                                                     input logic [7:0] d);
        xbs_pkg::t_result r;
        logic [7:0]  b;
        logic [7:0]  last;
        logic [15:0] c;
        int          idx;
        r = '0;
        b = 8'h00;
        case (op)
            xbs_pkg::OP_PAYLOAD: if (m_phase == PH_LOAD) begin
                r.accepted = 1'b1;
                m_store[m_fill[6:0]] = d;
                m_fill = m_fill + 8'd1;
                if (m_fill >= 8'(BLOCK_LEN)) begin
                    m_phase = PH_SEND;
                    m_pos = 8'd0;
                end
            end
            xbs_pkg::OP_EOF: if (m_phase == PH_LOAD) begin
                r.accepted = 1'b1;
                if (m_fill == 8'd0) begin
                    m_phase = PH_EOT;
                end else begin
                    m_end = 1'b1;
                    m_phase = PH_SEND;
                    m_pos = 8'd0;
                end
            end
            xbs_pkg::OP_RX: if (m_phase == PH_SYNC) begin
                r.accepted = 1'b1;
                if (d == (m_crc_mode ? CH_SYNC_C : CH_NAK))
                    m_phase = PH_LOAD;
            end else if (m_phase == PH_WAIT) begin
                r.accepted = 1'b1;
                if (d == CH_ACK) begin
                    if (m_end) begin
                        m_phase = PH_EOT;
                    end else begin
                        m_blk = m_blk + 8'd1;
                        m_fill = 8'd0;
                        m_phase = PH_LOAD;
                    end
                end else if (d == CH_NAK) begin
                    resends++;
                    m_phase = PH_SEND;
                    m_pos = 8'd0;
                end else if (d == CH_CAN) begin
                    m_phase = PH_CANCEL;
                end else begin
                    m_phase = PH_ERROR;
                end
            end
            default: if (m_phase == PH_SEND) begin
                r.accepted = 1'b1;
                r.tx_valid = 1'b1;
                last = m_crc_mode ? 8'd132 : 8'd131;
                if (m_pos == 8'd0) begin
                    m_sum = 8'd0;
                    m_crc = 16'd0;
                    b = CH_SOH;
                    blocks_sent++;
                end else if (m_pos == 8'd1) begin
                    b = m_blk;
                end else if (m_pos == 8'd2) begin
                    b = 8'd255 - m_blk;
                end else if (m_pos < 8'd131) begin
                    idx = int'(m_pos) - 3;
                    b = (idx < int'(m_fill)) ? m_store[idx[6:0]] : 8'h00;
                    m_sum = m_sum + b;
                    c = m_crc ^ {b, 8'h00};
                    for (int k = 0; k < 8; k++)
                        c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
                    m_crc = c;
                end else if (!m_crc_mode) begin
                    b = m_sum;
                end else if (m_pos == 8'd131) begin
                    b = m_crc[15:8];
                end else begin
                    b = m_crc[7:0];
                end
                if (m_pos >= last) begin
                    m_phase = PH_WAIT;
                    m_pos = 8'd0;
                end else begin
                    m_pos = m_pos + 8'd1;
                end
            end else if (m_phase == PH_EOT) begin
                r.accepted = 1'b1;
                r.tx_valid = 1'b1;
                b = CH_EOT;
                m_phase = PH_DONE;
            end
        endcase
        r.tx_byte = b;
        r.phase = m_phase;
        r.block_number = m_blk;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input xbs_pkg::t_op op, input logic [7:0] d);
        int      gap;
        xbs_pkg::t_result r;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_action <= op;
        i_data_byte <= d;
        @(posedge i_clk);
        while (full) begin
            @(negedge i_clk);
            @(posedge i_clk);
        end
        r = step_sender(op, d);
        expected_results.push_back(r);
        if (r.accepted)
            taken_count++;
        else
            rejected_count++;
        @(negedge i_clk);
    endtask

    // Mode register is only written with nothing in flight.
    task automatic set_mode(input logic mode);
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        m_crc_mode = mode;
        mode_writes++;
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        error_count++;
        if (error_count <= 40)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Sync phase: wrong-phase words, noise bytes, the other mode's sync byte, a mode change, then sync.
    task automatic test_sync();
        set_mode(1'($urandom_range(0, 1)));
        send_word(xbs_pkg::OP_PAYLOAD, 8'hFF);
        send_word(xbs_pkg::OP_EOF, 8'h00);
        send_word(xbs_pkg::OP_SLOT, 8'hA5);
        send_word(xbs_pkg::OP_RX, 8'h00);
        send_word(xbs_pkg::OP_RX, 8'hFF);
        send_word(xbs_pkg::OP_RX, m_crc_mode ? CH_NAK : CH_SYNC_C);
        send_word(xbs_pkg::OP_RX, CH_ACK);
        set_mode(!m_crc_mode);
        send_word(xbs_pkg::OP_RX, m_crc_mode ? CH_NAK : CH_SYNC_C);
        send_word(xbs_pkg::OP_RX, m_crc_mode ? CH_SYNC_C : CH_NAK);
        // now loading: replies and slots are out of phase
        send_word(xbs_pkg::OP_RX, CH_ACK);
        send_word(xbs_pkg::OP_SLOT, 8'h5A);
    endtask

    // Full blocks with random data, ACK/NAK replies, stray words and mode changes.
    task automatic test_block_traffic();
        int r;
        while (taken_count < TAKEN_TARGET) begin
            if ($urandom_range(0, 99) == 0)
                quiet = !quiet;
            if ($urandom_range(0, 199) == 0)
                set_mode(1'($urandom_range(0, 1)));
            r = $urandom_range(0, 99);
            case (m_phase)
                PH_LOAD: begin
                    if (r < 3)
                        send_word(r[0] ? xbs_pkg::OP_RX : xbs_pkg::OP_SLOT,
                                  8'($urandom_range(0, 255)));
                    else
                        send_word(xbs_pkg::OP_PAYLOAD, pick_payload());
                end
                PH_SEND: begin
                    if (r < 3)
                        send_word(xbs_pkg::t_op'(r), 8'($urandom_range(0, 255)));
                    else
                        send_word(xbs_pkg::OP_SLOT, 8'($urandom_range(0, 255)));
                end
                default: begin
                    if (r < 10)
                        send_word(r < 4 ? xbs_pkg::OP_PAYLOAD
                                        : (r < 7 ? xbs_pkg::OP_EOF : xbs_pkg::OP_SLOT),
                                  8'($urandom_range(0, 255)));
                    else
                        send_word(xbs_pkg::OP_RX, r < 72 ? CH_ACK : CH_NAK);
                end
            endcase
        end
        quiet = 1'b0;
    endtask

    // One of the four ways a transfer ends, then words into the terminal phase.
    task automatic test_transfer_end();
        int         ending;
        logic [7:0] b;
        ending = $urandom_range(0, 3);
        while (m_phase != PH_LOAD)
            if (m_phase == PH_SEND)
                send_word(xbs_pkg::OP_SLOT, 8'($urandom_range(0, 255)));
            else
                send_word(xbs_pkg::OP_RX, CH_ACK);
        if (ending == 0 && m_fill != 8'd0) begin
            while (m_phase == PH_LOAD)
                send_word(xbs_pkg::OP_PAYLOAD, pick_payload());
            while (m_phase == PH_SEND)
                send_word(xbs_pkg::OP_SLOT, 8'($urandom_range(0, 255)));
            send_word(xbs_pkg::OP_RX, CH_ACK);
        end
        if (ending != 0 && m_fill == 8'd0)
            repeat ($urandom_range(1, BLOCK_LEN - 1))
                send_word(xbs_pkg::OP_PAYLOAD, pick_payload());
        send_word(xbs_pkg::OP_EOF, 8'($urandom_range(0, 255)));
        while (m_phase == PH_SEND)
            send_word(xbs_pkg::OP_SLOT, 8'($urandom_range(0, 255)));
        case (ending)
            0: begin
                end_name = "end of file on an empty block";
                send_word(xbs_pkg::OP_RX, CH_ACK);
                send_word(xbs_pkg::OP_SLOT, 8'h00);
            end
            1: begin
                end_name = "end of file on a partial block";
                if ($urandom_range(0, 1)) begin
                    send_word(xbs_pkg::OP_RX, CH_NAK);
                    while (m_phase == PH_SEND)
                        send_word(xbs_pkg::OP_SLOT, 8'($urandom_range(0, 255)));
                end
                send_word(xbs_pkg::OP_RX, CH_ACK);
                send_word(xbs_pkg::OP_PAYLOAD, 8'hFF);
                send_word(xbs_pkg::OP_SLOT, 8'hFF);
            end
            2: begin
                end_name = "cancel from the receiver";
                send_word(xbs_pkg::OP_RX, CH_CAN);
            end
            default: begin
                end_name = "an unknown reply";
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_ACK || b == CH_NAK || b == CH_CAN);
                send_word(xbs_pkg::OP_RX, b);
            end
        endcase
        // terminal phases take nothing until reset
        repeat (20)
            send_word(xbs_pkg::t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else if (!quiet && $urandom_range(0, 99) < 10) begin
                pop <= 1'b0;
                stall = $urandom_range(0, 9) == 0 ? $urandom_range(8, 40)
                                                  : $urandom_range(0, 2);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        xbs_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                report("result word with nothing expected", 16'({o_accepted, o_tx_byte}),
                       16'h0);
            end else begin
                want = expected_results.pop_front();
                if (o_tx_valid !== want.tx_valid)
                    report("tx_valid", 16'(o_tx_valid), 16'(want.tx_valid));
                if (o_tx_byte !== want.tx_byte)
                    report("tx_byte", 16'(o_tx_byte), 16'(want.tx_byte));
                if (o_accepted !== want.accepted)
                    report("accepted", 16'(o_accepted), 16'(want.accepted));
                if (o_phase !== want.phase)
                    report("phase", 16'(o_phase), 16'(want.phase));
                if (o_block_number !== want.block_number)
                    report("block_number", 16'(o_block_number), 16'(want.block_number));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_IDLE) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_IDLE);
            $display("tb_xmodem_block_sender_top NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_sync();
        test_block_traffic();
        test_transfer_end();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        $display("covered %0d words taken and %0d rejected, %0d block sends (%0d on NAK)",
                 taken_count, rejected_count, blocks_sent, resends);
        $display("%0d mode writes, transfer ended by %s, %0d mismatches",
                 mode_writes, end_name, error_count);
        if (error_count == 0)
            $display("tb_xmodem_block_sender_top OK");
        else
            $display("tb_xmodem_block_sender_top NOT OK");
        $finish;
    end

endmodule
